@@ src/madt_pkg.sv @@
package madt_pkg;

  localparam int unsigned MAX_CPUS     = 64;
  localparam int unsigned MAX_IRQ_CTRL = 16;

  localparam logic [31:0] HDR_BYTES    = 32'd44;
  localparam logic [31:0] LEN_LAST_OFF = 32'd7;
  localparam logic [31:0] OFF_MAX      = 32'hFFFF_FFFF;

  localparam logic [7:0] ET_LAPIC  = 8'd0;
  localparam logic [7:0] ET_IOAPIC = 8'd1;
  localparam logic [7:0] ET_X2APIC = 8'd9;
  localparam logic [7:0] ET_GICC   = 8'd11;
  localparam logic [7:0] ET_GICD   = 8'd12;

  localparam logic [16:0] IOAPIC_SIZE  = 17'h00020;
  localparam logic [16:0] GICD_SIZE    = 17'h10000;
  localparam logic [4:0]  IOAPIC_LINES = 5'd24;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_CPU    = 2'd0,
    KIND_IOAPIC = 2'd1,
    KIND_GICD   = 2'd2,
    KIND_END    = 2'd3
  } rec_kind_t;

  typedef enum logic [1:0] {
    END_OK        = 2'd0,
    END_SHORT_HDR = 2'd1,
    END_BAD_LEN   = 2'd2
  } end_status_t;

  typedef struct packed {
    rec_kind_t   kind;
    logic [63:0] ident;
    logic [16:0] size;
    logic [31:0] first;
    logic [4:0]  lines;
    end_status_t status;
  } rec_t;

  // Records produced by one byte, packed from slot 0 upwards
  typedef struct packed {
    logic [1:0] count;
    rec_t       rec0;
    rec_t       rec1;
  } emit_t;

endpackage

@@ src/madt_parse_core.sv @@
module madt_parse_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       byte_in,
  input  logic             start_in,
  output madt_pkg::emit_t  emit
);
  import madt_pkg::*;

  logic [31:0] byte_offset, byte_offset_next;
  logic [31:0] table_length, table_length_next;
  logic [31:0] entry_start, entry_start_next;
  logic [7:0]  entry_type, entry_type_next;
  logic [7:0]  entry_length, entry_length_next;
  logic        entry_en, entry_en_next;
  logic [63:0] captured_ident, captured_ident_next;
  logic [31:0] captured_gsi, captured_gsi_next;
  logic        walk_stopped, walk_stopped_next;
  logic [7:0]  cpus_seen, cpus_seen_next;
  logic [5:0]  controllers_seen, controllers_seen_next;

  logic [31:0] off;
  logic [31:0] rel;
  logic [2:0]  pos;
  logic        live;
  logic        end_check;
  logic        finish;
  logic        is_cpu, is_ioapic, is_gicd;
  logic        ent_valid, end_valid;
  rec_t        ent_rec, end_rec;

  always_comb begin
    off                   = start_in ? 32'd0 : byte_offset;
    byte_offset_next      = (off == OFF_MAX) ? off : off + 32'd1;
    table_length_next     = (off == 32'd0) ? 32'd0 : table_length;
    entry_start_next      = (off == 32'd0) ? 32'd0 : entry_start;
    walk_stopped_next     = (start_in || off == 32'd0) ? 1'b0 : walk_stopped;
    entry_type_next       = entry_type;
    entry_length_next     = entry_length;
    entry_en_next         = entry_en;
    captured_ident_next   = captured_ident;
    captured_gsi_next     = captured_gsi;
    cpus_seen_next        = cpus_seen;
    controllers_seen_next = controllers_seen;
    rel                   = off - entry_start_next;
    pos                   = rel[2:0] - 3'd4;
    live                  = !walk_stopped_next;
    end_check             = 1'b0;
    finish                = 1'b0;
    is_cpu                = 1'b0;
    is_ioapic             = 1'b0;
    is_gicd               = 1'b0;
    ent_valid             = 1'b0;
    end_valid             = 1'b0;
    ent_rec               = '0;
    end_rec               = '0;
    end_rec.kind          = KIND_END;

    if (live) begin
      if (off < HDR_BYTES) begin
        end_check = 1'b1;
        if (off >= 32'd4 && off <= LEN_LAST_OFF) begin
          case (off[1:0])
            2'd0:    table_length_next[7:0]   = byte_in;
            2'd1:    table_length_next[15:8]  = byte_in;
            2'd2:    table_length_next[23:16] = byte_in;
            default: table_length_next[31:24] = byte_in;
          endcase
        end
        if (off == LEN_LAST_OFF) begin
          if (table_length_next < HDR_BYTES) begin
            walk_stopped_next = 1'b1;
            end_valid         = 1'b1;
            end_rec.status    = END_SHORT_HDR;
            end_check         = 1'b0;
          end else begin
            entry_start_next = HDR_BYTES;
          end
        end
      end else if (off < table_length_next && off >= entry_start_next) begin
        if (rel == 32'd0) begin
          end_check           = 1'b1;
          entry_type_next     = byte_in;
          entry_length_next   = 8'd0;
          entry_en_next       = 1'b0;
          captured_ident_next = '0;
          captured_gsi_next   = '0;
        end else if (rel == 32'd1) begin
          entry_length_next = byte_in;
          if (byte_in < 8'd2 ||
              ({1'b0, entry_start_next} + {25'd0, byte_in}) > {1'b0, table_length_next}) begin
            walk_stopped_next = 1'b1;
            end_valid         = 1'b1;
            end_rec.status    = END_BAD_LEN;
          end else begin
            end_check = 1'b1;
            finish    = (byte_in == 8'd2);
          end
        end else begin
          end_check = 1'b1;
          // capture fields at fixed offsets inside the entry
          case (entry_type)
            ET_LAPIC: begin
              if (rel == 32'd3) captured_ident_next = {56'd0, byte_in};
              else if (rel == 32'd4) entry_en_next = byte_in[0];
            end
            ET_IOAPIC: begin
              if (rel >= 32'd4 && rel <= 32'd7)
                captured_ident_next[{rel[1:0], 3'b000} +: 8] = byte_in;
              else if (rel >= 32'd8 && rel <= 32'd11)
                captured_gsi_next[{rel[1:0], 3'b000} +: 8] = byte_in;
            end
            ET_X2APIC: begin
              if (rel >= 32'd4 && rel <= 32'd7)
                captured_ident_next[{rel[1:0], 3'b000} +: 8] = byte_in;
              else if (rel == 32'd8) entry_en_next = byte_in[0];
            end
            ET_GICC: begin
              if (rel == 32'd12) entry_en_next = byte_in[0];
              else if (rel >= 32'd68 && rel <= 32'd75)
                captured_ident_next[{pos, 3'b000} +: 8] = byte_in;
            end
            ET_GICD: begin
              if (rel >= 32'd8 && rel <= 32'd15)
                captured_ident_next[{rel[2:0], 3'b000} +: 8] = byte_in;
            end
            default: ;
          endcase
          finish = (rel == ({24'd0, entry_length} - 32'd1));
        end
      end

      if (finish) begin
        is_cpu    = entry_en_next &&
                    ((entry_type_next == ET_LAPIC  && entry_length_next >= 8'd8)  ||
                     (entry_type_next == ET_X2APIC && entry_length_next >= 8'd16) ||
                     (entry_type_next == ET_GICC   && entry_length_next >= 8'd80));
        is_ioapic = (entry_type_next == ET_IOAPIC && entry_length_next >= 8'd12);
        is_gicd   = (entry_type_next == ET_GICD && entry_length_next >= 8'd24);
        ent_rec.ident = captured_ident_next;
        if (is_cpu && cpus_seen < 8'(MAX_CPUS)) begin
          cpus_seen_next = cpus_seen + 8'd1;
          ent_valid      = 1'b1;
          ent_rec.kind   = KIND_CPU;
        end else if ((is_ioapic || is_gicd) && controllers_seen < 6'(MAX_IRQ_CTRL)) begin
          controllers_seen_next = controllers_seen + 6'd1;
          ent_valid             = 1'b1;
          if (is_ioapic) begin
            ent_rec.kind  = KIND_IOAPIC;
            ent_rec.size  = IOAPIC_SIZE;
            ent_rec.first = captured_gsi_next;
            ent_rec.lines = IOAPIC_LINES;
          end else begin
            ent_rec.kind = KIND_GICD;
            ent_rec.size = GICD_SIZE;
          end
        end
        entry_start_next = entry_start_next + {24'd0, entry_length_next};
      end

      if (end_check && off >= LEN_LAST_OFF && off == table_length_next - 32'd1) begin
        walk_stopped_next = 1'b1;
        end_valid         = 1'b1;
        end_rec.status    = END_OK;
      end
    end

    emit.count = {1'b0, ent_valid} + {1'b0, end_valid};
    emit.rec0  = ent_valid ? ent_rec : end_rec;
    emit.rec1  = end_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset      <= '0;
      table_length     <= '0;
      entry_start      <= '0;
      entry_type       <= '0;
      entry_length     <= '0;
      entry_en         <= 1'b0;
      captured_ident   <= '0;
      captured_gsi     <= '0;
      walk_stopped     <= 1'b0;
      cpus_seen        <= '0;
      controllers_seen <= '0;
    end else if (step) begin
      byte_offset      <= byte_offset_next;
      table_length     <= table_length_next;
      entry_start      <= entry_start_next;
      entry_type       <= entry_type_next;
      entry_length     <= entry_length_next;
      entry_en         <= entry_en_next;
      captured_ident   <= captured_ident_next;
      captured_gsi     <= captured_gsi_next;
      walk_stopped     <= walk_stopped_next;
      cpus_seen        <= cpus_seen_next;
      controllers_seen <= controllers_seen_next;
    end
  end

endmodule

@@ src/madt_rec_fifo.sv @@
module madt_rec_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  madt_pkg::emit_t  emit,
  input  logic             pop,
  output logic             not_empty,
  output logic             room_for_two,
  output madt_pkg::rec_t   head_rec
);
  import madt_pkg::*;

  rec_t                 mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   rd_ptr, rd_ptr_next;
  logic [FIFO_AW-1:0]   wr_ptr, wr_ptr_next;
  logic [FIFO_CW-1:0]   count, count_next;
  logic [FIFO_CW-1:0]   push_cnt;
  logic [FIFO_AW-1:0]   wr_ptr_plus;

  always_comb begin
    push_cnt    = push ? FIFO_CW'(emit.count) : '0;
    wr_ptr_plus = wr_ptr + FIFO_AW'(1);
    wr_ptr_next = wr_ptr + FIFO_AW'(push_cnt);
    rd_ptr_next = pop ? rd_ptr + FIFO_AW'(1) : rd_ptr;
    count_next  = count + push_cnt - (pop ? FIFO_CW'(1) : FIFO_CW'(0));
  end

  assign not_empty    = (count != '0);
  assign room_for_two = (count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign head_rec     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && emit.count != 2'd0) mem[wr_ptr] <= emit.rec0;
    if (push && emit.count == 2'd2) mem[wr_ptr_plus] <= emit.rec1;
  end

endmodule

@@ src/madt_entry_stream_parser_unit.sv @@
// A byte taken in is held in an input register until the record queue can take two
// more records; it is then parsed and its records are written to the queue and offered.
// Throughput: one table byte per cycle; input stalls only while the four-deep
// record queue cannot take two more records.
// Reset (rst, synchronous): clears the parse state, the CPU and controller
// counts and the queue; the first byte after reset opens a new table.
module madt_entry_stream_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        table_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  record_kind,
  output logic [63:0] ident_or_base,
  output logic [16:0] region_size,
  output logic [31:0] irq_first,
  output logic [4:0]  irq_lines,
  output logic [1:0]  end_status
);
  import madt_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_start;
  logic       advance;
  logic       room_for_two;
  emit_t      emit;
  rec_t       head_rec;

  assign advance  = hold_valid && room_for_two;
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte  <= data_byte;
      hold_start <= table_start;
    end
  end

  madt_parse_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .byte_in  (hold_byte),
    .start_in (hold_start),
    .emit     (emit)
  );

  madt_rec_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (advance),
    .emit         (emit),
    .pop          (out_valid && out_ready),
    .not_empty    (out_valid),
    .room_for_two (room_for_two),
    .head_rec     (head_rec)
  );

  assign record_kind   = head_rec.kind;
  assign ident_or_base = head_rec.ident;
  assign region_size   = head_rec.size;
  assign irq_first     = head_rec.first;
  assign irq_lines     = head_rec.lines;
  assign end_status    = head_rec.status;

  a_stall_means_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> hold_valid && !room_for_two)
    else $error("input stalled without a held byte blocked by the queue");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !hold_valid)
    else $error("queue or input stage not empty after reset");

  a_end_rec_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind == KIND_END |-> ident_or_base == 64'd0 && irq_lines == 5'd0)
    else $error("end record carries entry data");

  a_ioapic_lines: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind == KIND_IOAPIC |->
      irq_lines == IOAPIC_LINES && region_size == IOAPIC_SIZE)
    else $error("io apic record malformed");

endmodule

@@ sim/tb_madt_entry_stream_parser_unit.sv @@
`timescale 1ns / 100ps

module tb_madt_entry_stream_parser_unit;
  import madt_pkg::*;

  localparam int LAPIC_LEN    = 8;
  localparam int IOAPIC_LEN   = 12;
  localparam int X2APIC_LEN   = 16;
  localparam int GICC_LEN     = 80;
  localparam int GICD_LEN     = 24;
  localparam int RANDOM_ITEMS = 400;
  localparam int ITEM_CAP     = 6000;
  localparam int LONG_HOLD    = 120;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int N_DIR        = 27;

  typedef struct packed {
    logic [7:0]  b;
    logic        s;
    logic        typed;
    end_status_t st;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // no start mark after reset; header declares 43 bytes
    '{8'h41, 1'b0, 1'b0, END_OK}, '{8'h50, 1'b0, 1'b0, END_OK},
    '{8'h49, 1'b0, 1'b0, END_OK}, '{8'h43, 1'b0, 1'b0, END_OK},
    '{8'h2B, 1'b0, 1'b0, END_OK}, '{8'h00, 1'b0, 1'b0, END_OK},
    '{8'h00, 1'b0, 1'b0, END_OK}, '{8'h00, 1'b0, 1'b1, END_SHORT_HDR},
    // dropped: walk already stopped
    '{8'hFF, 1'b0, 1'b0, END_OK},
    // all-ones signature, zero length
    '{8'hFF, 1'b1, 1'b0, END_OK}, '{8'hFF, 1'b0, 1'b0, END_OK},
    '{8'hFF, 1'b0, 1'b0, END_OK}, '{8'hFF, 1'b0, 1'b0, END_OK},
    '{8'h00, 1'b0, 1'b0, END_OK}, '{8'h00, 1'b0, 1'b0, END_OK},
    '{8'h00, 1'b0, 1'b0, END_OK}, '{8'h00, 1'b0, 1'b1, END_SHORT_HDR},
    // abandoned after two bytes by a new start
    '{8'h12, 1'b1, 1'b0, END_OK}, '{8'h34, 1'b0, 1'b0, END_OK},
    // maximum declared length, left open
    '{8'h00, 1'b1, 1'b0, END_OK}, '{8'h00, 1'b0, 1'b0, END_OK},
    '{8'h00, 1'b0, 1'b0, END_OK}, '{8'h00, 1'b0, 1'b0, END_OK},
    '{8'hFF, 1'b0, 1'b0, END_OK}, '{8'hFF, 1'b0, 1'b0, END_OK},
    '{8'hFF, 1'b0, 1'b0, END_OK}, '{8'hFF, 1'b0, 1'b0, END_OK}
  };

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte     = 8'h00;
  logic        table_start   = 1'b0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [1:0]  record_kind;
  logic [63:0] ident_or_base;
  logic [16:0] region_size;
  logic [31:0] irq_first;
  logic [4:0]  irq_lines;
  logic [1:0]  end_status;

  // parser state mirror
  logic [31:0] m_off       = '0;
  logic [31:0] m_tlen      = '0;
  logic [31:0] m_ent_start = '0;
  logic [7:0]  m_etype     = '0;
  logic [7:0]  m_elen      = '0;
  logic [31:0] m_flags     = '0;
  logic [63:0] m_ident     = '0;
  logic [31:0] m_gsi       = '0;
  logic        m_stopped   = 1'b0;
  int unsigned n_cpus      = 0;
  int unsigned n_ctrls     = 0;

  rec_t        byte_records[$];
  rec_t        pending_records[$];
  logic [7:0]  tx_bytes[$];
  logic        tx_start[$];

  bit          idle_on       = 1'b0;
  int          hold_requests = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;
  int          stall_left    = 0;
  int          n_mismatch    = 0;
  int          bytes_sent    = 0;
  int          cycle_cnt     = 0;

  madt_entry_stream_parser_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .table_start   (table_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .record_kind   (record_kind),
    .ident_or_base (ident_or_base),
    .region_size   (region_size),
    .irq_first     (irq_first),
    .irq_lines     (irq_lines),
    .end_status    (end_status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic rec_t make_record(rec_kind_t k, logic [63:0] id, logic [16:0] sz,
                                       logic [31:0] first, logic [4:0] lines,
                                       end_status_t st);
    rec_t r;
    r.kind   = k;
    r.ident  = id;
    r.size   = sz;
    r.first  = first;
    r.lines  = lines;
    r.status = st;
    return r;
  endfunction

  task automatic capture_field(input logic [31:0] r, input logic [7:0] b);
    case (m_etype)
      ET_LAPIC: begin
        if (r == 3) m_ident = {56'b0, b};
        else if (r >= 4 && r <= 7) m_flags[8*(r-4) +: 8] = b;
      end
      ET_IOAPIC: begin
        if (r >= 4 && r <= 7) m_ident[8*(r-4) +: 8] = b;
        else if (r >= 8 && r <= 11) m_gsi[8*(r-8) +: 8] = b;
      end
      ET_X2APIC: begin
        if (r >= 4 && r <= 7) m_ident[8*(r-4) +: 8] = b;
        else if (r >= 8 && r <= 11) m_flags[8*(r-8) +: 8] = b;
      end
      ET_GICC: begin
        if (r >= 12 && r <= 15) m_flags[8*(r-12) +: 8] = b;
        else if (r >= 68 && r <= 75) m_ident[8*(r-68) +: 8] = b;
      end
      ET_GICD: begin
        if (r >= 8 && r <= 15) m_ident[8*(r-8) +: 8] = b;
      end
      default: ;
    endcase
  endtask

  task automatic close_entry();
    logic en, is_cpu, is_io, is_gicd;
    en      = m_flags[0];
    is_cpu  = en && ((m_etype == ET_LAPIC && m_elen >= LAPIC_LEN) ||
                     (m_etype == ET_X2APIC && m_elen >= X2APIC_LEN) ||
                     (m_etype == ET_GICC && m_elen >= GICC_LEN));
    is_io   = m_etype == ET_IOAPIC && m_elen >= IOAPIC_LEN;
    is_gicd = m_etype == ET_GICD && m_elen >= GICD_LEN;
    if (is_cpu && n_cpus < MAX_CPUS) begin
      n_cpus++;
      byte_records.push_back(make_record(KIND_CPU, m_ident, '0, '0, '0, END_OK));
    end else if ((is_io || is_gicd) && n_ctrls < MAX_IRQ_CTRL) begin
      n_ctrls++;
      if (is_io)
        byte_records.push_back(make_record(KIND_IOAPIC, m_ident, IOAPIC_SIZE, m_gsi,
                                           IOAPIC_LINES, END_OK));
      else
        byte_records.push_back(make_record(KIND_GICD, m_ident, GICD_SIZE, '0, '0, END_OK));
    end
    m_ent_start = m_ent_start + {24'b0, m_elen};
  endtask

  // Work out the records one table byte produces into byte_records
  task automatic parse_table_byte(input logic [7:0] b, input logic s);
    logic [31:0] off, r;
    byte_records.delete();
    if (s) begin
      m_off     = '0;
      m_stopped = 1'b0;
    end
    off = m_off;
    if (m_off != OFF_MAX) m_off = m_off + 32'd1;
    if (off == 0) begin
      m_tlen      = '0;
      m_ent_start = '0;
      m_stopped   = 1'b0;
    end
    if (m_stopped) return;
    if (off < HDR_BYTES) begin
      if (off >= 4 && off <= LEN_LAST_OFF) m_tlen[8*(off-4) +: 8] = b;
      if (off == LEN_LAST_OFF) begin
        if (m_tlen < HDR_BYTES) begin
          m_stopped = 1'b1;
          byte_records.push_back(make_record(KIND_END, '0, '0, '0, '0, END_SHORT_HDR));
          return;
        end
        m_ent_start = HDR_BYTES;
      end
    end else begin
      if (off >= m_tlen || off < m_ent_start) return;
      r = off - m_ent_start;
      if (r == 0) begin
        m_etype = b;
        m_elen  = '0;
        m_flags = '0;
        m_ident = '0;
        m_gsi   = '0;
      end else if (r == 1) begin
        m_elen = b;
        if (m_elen < 2 || {1'b0, m_ent_start} + {25'b0, m_elen} > {1'b0, m_tlen}) begin
          m_stopped = 1'b1;
          byte_records.push_back(make_record(KIND_END, '0, '0, '0, '0, END_BAD_LEN));
          return;
        end
        if (m_elen == 2) close_entry();
      end else begin
        capture_field(r, b);
        if (r == {24'b0, m_elen} - 32'd1) close_entry();
      end
    end
    if (off >= LEN_LAST_OFF && off == m_tlen - 32'd1) begin
      m_stopped = 1'b1;
      byte_records.push_back(make_record(KIND_END, '0, '0, '0, '0, END_OK));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic s, input logic typed,
                           input end_status_t st);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    table_start <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_table_byte(b, s);
    if (typed)
      pending_records.push_back(make_record(KIND_END, '0, '0, '0, '0, st));
    else
      foreach (byte_records[k]) pending_records.push_back(byte_records[k]);
    bytes_sent++;
  endtask

  task automatic add_entry(input bit dense);
    int sel, min_len, elen, foff, at;
    logic [7:0] etype;
    sel  = dense ? (($urandom_range(0, 3) == 0) ? 6 : 0) : $urandom_range(0, 15);
    foff = 0;
    if (sel <= 5) begin
      etype = ET_LAPIC;  min_len = LAPIC_LEN;  foff = 4;
    end else if (sel <= 7) begin
      etype = ET_IOAPIC; min_len = IOAPIC_LEN;
    end else if (sel <= 9) begin
      etype = ET_X2APIC; min_len = X2APIC_LEN; foff = 8;
    end else if (sel == 10) begin
      etype = ET_GICC;   min_len = GICC_LEN;   foff = 12;
    end else if (sel <= 12) begin
      etype = ET_GICD;   min_len = GICD_LEN;
    end else begin
      etype = 8'($urandom_range(0, 255)); min_len = $urandom_range(2, 20);
    end
    elen = min_len;
    if (!dense) begin
      if (min_len > 2 && $urandom_range(0, 9) == 0) elen = $urandom_range(2, min_len - 1);
      else if ($urandom_range(0, 7) == 0) elen = min_len + $urandom_range(1, 4);
    end
    at = tx_bytes.size();
    tx_bytes.push_back(etype);
    tx_bytes.push_back(8'(elen));
    repeat (elen - 2) tx_bytes.push_back(8'($urandom_range(0, 255)));
    // force the enable bit, mostly set
    if (foff != 0 && foff < elen)
      tx_bytes[at+foff] = (tx_bytes[at+foff] & 8'hFE) |
                          ((dense || $urandom_range(0, 3) != 0) ? 8'h01 : 8'h00);
  endtask

  task automatic build_table(input bit dense, input bit force_wf);
    int sel, bad_at, lb;
    logic [31:0] declared;
    logic first_start;
    tx_bytes.delete();
    tx_start.delete();
    sel = force_wf ? 19 : $urandom_range(0, 19);
    if (sel == 0) begin
      // noise with stray start marks
      repeat ($urandom_range(1, 12)) begin
        tx_bytes.push_back(8'($urandom_range(0, 255)));
        tx_start.push_back($urandom_range(0, 5) == 0);
      end
      return;
    end
    repeat (HDR_BYTES) tx_bytes.push_back(8'($urandom_range(0, 255)));
    if (sel <= 2) begin
      declared = $urandom_range(0, HDR_BYTES - 1);
    end else begin
      repeat (dense ? $urandom_range(12, 24) : $urandom_range(0, 12)) add_entry(dense);
      if (!dense && $urandom_range(0, 7) == 0) begin
        bad_at = tx_bytes.size();
        tx_bytes.push_back(8'($urandom_range(0, 255)));
        tx_bytes.push_back(8'h00);
        repeat ($urandom_range(0, 5)) tx_bytes.push_back(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 2))
          0:       lb = 0;
          1:       lb = 1;
          default: lb = tx_bytes.size() - bad_at + 1 + $urandom_range(0, 3);
        endcase
        tx_bytes[bad_at+1] = 8'(lb);
      end else if ($urandom_range(0, 4) == 0) begin
        // lone trailing byte, too short for an entry header
        tx_bytes.push_back(8'($urandom_range(0, 255)));
      end
      declared = tx_bytes.size();
      if ($urandom_range(0, 11) == 0) declared = declared + $urandom_range(1, 30);
    end
    for (int k = 0; k < 4; k++) tx_bytes[4+k] = declared[8*k +: 8];
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) tx_bytes.push_back(8'($urandom_range(0, 255)));
    first_start = $urandom_range(0, 19) != 0;
    for (int k = 0; k < tx_bytes.size(); k++) tx_start.push_back(k == 0 ? first_start : 1'b0);
  endtask

  task automatic check_record();
    rec_t want;
    if (pending_records.size() == 0) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("unexpected record: kind=%0d ident=%h size=%h first=%h lines=%0d status=%0d",
                 record_kind, ident_or_base, region_size, irq_first, irq_lines, end_status);
    end else begin
      want = pending_records.pop_front();
      if (record_kind !== want.kind || ident_or_base !== want.ident ||
          region_size !== want.size || irq_first !== want.first ||
          irq_lines !== want.lines || end_status !== want.status) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("record mismatch: exp kind=%0d ident=%h size=%h first=%h lines=%0d st=%0d",
                   want.kind, want.ident, want.size, want.first, want.lines, want.status);
          $display("                 got kind=%0d ident=%h size=%h first=%h lines=%0d st=%0d",
                   record_kind, ident_or_base, region_size, irq_first, irq_lines, end_status);
        end
      end
    end
  endtask

  // record sink: per-record stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_record();
        stall_left = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("madt_entry_stream_parser_unit test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int  tbl;
    bit  dense;
    bit  dense_held;
    dense_held = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++)
      send_byte(DIR_ROWS[i].b, DIR_ROWS[i].s, DIR_ROWS[i].typed, DIR_ROWS[i].st);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);

    // keep going past the item target until both capacities have run out or the item cap is reached
    for (tbl = 0; (bytes_sent < RANDOM_ITEMS || n_cpus < MAX_CPUS ||
                   n_ctrls < MAX_IRQ_CTRL) && bytes_sent < ITEM_CAP; tbl++) begin
      dense   = bytes_sent >= RANDOM_ITEMS;
      idle_on = $urandom_range(0, 3) != 0;
      if (tbl == 1 || (dense && !dense_held)) begin
        // back-to-back bytes against a stalled sink to fill the record queue
        idle_on = 1'b0;
        hold_requests++;
        if (dense) dense_held = 1'b1;
        build_table(dense, 1'b1);
      end else begin
        build_table(dense, 1'b0);
      end
      for (int k = 0; k < tx_bytes.size(); k++) send_byte(tx_bytes[k], tx_start[k], 1'b0, END_OK);
      if (tbl % 4 == 3) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_records.size() != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_mismatch == 0)
      $display("madt_entry_stream_parser_unit test passed");
    else
      $display("madt_entry_stream_parser_unit test failed");
    $finish;
  end

endmodule

@@ files.f @@
src/madt_pkg.sv
src/madt_parse_core.sv
src/madt_rec_fifo.sv
src/madt_entry_stream_parser_unit.sv
sim/tb_madt_entry_stream_parser_unit.sv
